### rtl/packet_intrusion_classifier_macros.svh
`ifndef PACKET_INTRUSION_CLASSIFIER_MACROS_SVH
`define PACKET_INTRUSION_CLASSIFIER_MACROS_SVH
// assert that an antecedent implies a consequent
`define PIC_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// assert that an antecedent implies a consequent next cycle
`define PIC_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/pic_pkg.sv
package pic_pkg;
  localparam logic [15:0] EtherIpv4 = 16'h0800;
  localparam logic [15:0] EtherArp  = 16'h0806;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam int HostLen  = 5;
  localparam int Name1Len = 12;
  localparam int Name2Len = 7;

  typedef struct packed {
    logic syn;
    logic [31:0] src;
  } pic_status_t;

  typedef struct packed {
    logic start;
  } pic_cmd_t;

  typedef struct packed {
    logic busy;
    logic known;
    logic done;
  } pic_srch_t;

  function automatic logic [7:0] host_chr(input logic [2:0] i);
    case (i)
      3'd0: host_chr = 8'h48;
      3'd1: host_chr = 8'h6f;
      3'd2: host_chr = 8'h73;
      3'd3: host_chr = 8'h74;
      3'd4: host_chr = 8'h3a;
      default: host_chr = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] name1_chr(input logic [3:0] i);
    case (i)
      4'd0: name1_chr = 8'h67;
      4'd1: name1_chr = 8'h6f;
      4'd2: name1_chr = 8'h6f;
      4'd3: name1_chr = 8'h67;
      4'd4: name1_chr = 8'h6c;
      4'd5: name1_chr = 8'h65;
      4'd6: name1_chr = 8'h2e;
      4'd7: name1_chr = 8'h63;
      4'd8: name1_chr = 8'h6f;
      4'd9: name1_chr = 8'h2e;
      4'd10: name1_chr = 8'h75;
      4'd11: name1_chr = 8'h6b;
      default: name1_chr = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] name2_chr(input logic [2:0] i);
    case (i)
      3'd0: name2_chr = 8'h62;
      3'd1: name2_chr = 8'h62;
      3'd2: name2_chr = 8'h63;
      3'd3: name2_chr = 8'h2e;
      3'd4: name2_chr = 8'h63;
      3'd5: name2_chr = 8'h6f;
      3'd6: name2_chr = 8'h6d;
      default: name2_chr = 8'h00;
    endcase
  endfunction

  function automatic logic [2:0] host_step(input logic [2:0] p, input logic [7:0] c);
    logic [2:0] q;
    q = (p >= 3'(HostLen)) ? 3'd0 : p;
    if (q != 3'd0 && host_chr(q) != c) q = 3'd0;
    if (host_chr(q) == c) q = q + 3'd1;
    host_step = q;
  endfunction

  function automatic logic [3:0] name1_step(input logic [3:0] p, input logic [7:0] c);
    logic [3:0] q;
    q = (p >= 4'(Name1Len)) ? 4'd0 : p;
    if (q != 4'd0 && name1_chr(q) != c) q = (q == 4'd4) ? 4'd1 : 4'd0;
    if (q != 4'd0 && name1_chr(q) != c) q = 4'd0;
    if (name1_chr(q) == c) q = q + 4'd1;
    name1_step = q;
  endfunction

  function automatic logic [2:0] name2_step(input logic [2:0] p, input logic [7:0] c);
    logic [2:0] q;
    q = (p >= 3'(Name2Len)) ? 3'd0 : p;
    if (q != 3'd0 && name2_chr(q) != c) q = (q == 3'd2) ? 3'd1 : 3'd0;
    if (q != 3'd0 && name2_chr(q) != c) q = 3'd0;
    if (name2_chr(q) == c) q = q + 3'd1;
    name2_step = q;
  endfunction
endpackage

### rtl/pic_ram.sv
module pic_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/pic_parser.sv
module pic_parser import pic_pkg::*; #(
  parameter int MaxFrameBytes = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  input  logic [15:0] port_i,
  output pic_status_t stat_o,
  output logic        arp_o,
  output logic        hit_o
);
  logic [15:0] off_q, eth_q;
  logic [3:0]  ihl_q, thl_q;
  logic [7:0]  proto_q, flags_q;
  logic [31:0] src_q;
  logic [15:0] dport_q;
  logic [2:0]  hpos_q, n2_q;
  logic [3:0]  n1_q;
  logic        hfound_q, nhit_q;

  logic [17:0] t, p, o;
  logic        tcp_ok, scan, ipv4;
  logic [16:0] len;
  logic [2:0]  hnext, n2next;
  logic [3:0]  n1next;
  logic [15:0] eth_n;
  logic [31:0] src_n;
  logic        hit_n;

  always_comb begin
    o = {2'b0, off_q};
    t = 18'd14 + {12'b0, ihl_q, 2'b0};
    p = t + {12'b0, thl_q, 2'b0};
    tcp_ok = eth_q == EtherIpv4 && ihl_q >= 4'd5 && proto_q == ProtoTcp;
    scan = (off_q < 16'(MaxFrameBytes)) && tcp_ok && o >= t && thl_q >= 4'd5
           && o >= p && dport_q == port_i && !nhit_q;
    hnext = host_step(hpos_q, byte_i);
    n1next = name1_step(n1_q, byte_i);
    n2next = name2_step(n2_q, byte_i);
    eth_n = eth_q;
    src_n = src_q;
    if (off_q < 16'(MaxFrameBytes)) begin
      if (o == 18'd12) eth_n = {byte_i, 8'h00};
      else if (o == 18'd13) eth_n = {eth_q[15:8], byte_i};
      else if (o >= 18'd26 && o <= 18'd29) src_n = {src_q[23:0], byte_i};
    end
    hit_n = nhit_q || (scan && hfound_q &&
                       (n1next == 4'(Name1Len) || n2next == 3'(Name2Len)));
    len = (off_q < 16'(MaxFrameBytes)) ? {1'b0, off_q} + 17'd1 : {1'b0, off_q};
    ipv4 = eth_n == EtherIpv4 && len >= 17'd14;
    stat_o.src = (ipv4 && len >= 17'd30) ? src_n : 32'd0;
    stat_o.syn = ipv4 && ihl_q >= 4'd5 && proto_q == ProtoTcp && thl_q >= 4'd5
                 && {1'b0, len} >= p && (flags_q & 8'h3a) == 8'h02;
    arp_o = eth_n == EtherArp && len >= 17'd14;
    hit_o = hit_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0; eth_q <= '0; ihl_q <= '0; thl_q <= '0; proto_q <= '0;
      flags_q <= '0; src_q <= '0; dport_q <= '0; hpos_q <= '0; n1_q <= '0;
      n2_q <= '0; hfound_q <= 1'b0; nhit_q <= 1'b0;
    end else if (take_i && last_i) begin
      off_q <= '0; eth_q <= '0; ihl_q <= '0; thl_q <= '0; proto_q <= '0;
      flags_q <= '0; src_q <= '0; dport_q <= '0; hpos_q <= '0; n1_q <= '0;
      n2_q <= '0; hfound_q <= 1'b0; nhit_q <= 1'b0;
    end else if (take_i && off_q < 16'(MaxFrameBytes)) begin
      off_q <= off_q + 16'd1;
      if (o == 18'd12) eth_q <= {byte_i, 8'h00};
      else if (o == 18'd13) eth_q <= {eth_q[15:8], byte_i};
      else if (o == 18'd14) ihl_q <= byte_i[3:0];
      else if (o == 18'd23) proto_q <= byte_i;
      else if (o >= 18'd26 && o <= 18'd29) src_q <= {src_q[23:0], byte_i};
      if (tcp_ok && o >= t) begin
        if (o == t + 18'd2) dport_q <= {byte_i, 8'h00};
        else if (o == t + 18'd3) dport_q <= {dport_q[15:8], byte_i};
        else if (o == t + 18'd12) thl_q <= byte_i[7:4];
        else if (o == t + 18'd13) flags_q <= byte_i;
      end
      if (scan) begin
        if (!hfound_q) begin
          hpos_q <= hnext;
          if (hnext == 3'(HostLen)) hfound_q <= 1'b1;
        end else begin
          n1_q <= n1next;
          n2_q <= n2next;
          if (n1next == 4'(Name1Len) || n2next == 3'(Name2Len)) nhit_q <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/pic_search.sv
module pic_search import pic_pkg::*; #(
  parameter int Depth = 64,
  parameter int CntW  = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pic_cmd_t        cmd_i,
  input  logic [31:0]     addr_i,
  input  logic            store_i,
  input  logic [CntW-1:0] count_i,
  output pic_srch_t       srch_o
);
  localparam int AW = $clog2(Depth) > 0 ? $clog2(Depth) : 1;
  logic [CntW-1:0] idx_q;
  logic            busy_q, known_q, rd_q, done_q;
  logic [31:0]     rdata;
  logic [31:0]     key_q;
  logic            hit_now, fin;

  pic_ram #(.Width(32), .Depth(2 ** AW)) u_ram (
    .clk_i, .we_i(store_i), .waddr_i(count_i[AW-1:0]), .wdata_i(key_q),
    .raddr_i(idx_q[AW-1:0]), .rdata_o(rdata)
  );

  // rd_q means rdata holds entry idx_q-1
  assign hit_now = rd_q && rdata == key_q;
  assign fin = busy_q && !cmd_i.start && (idx_q >= count_i || hit_now);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; busy_q <= 1'b0; known_q <= 1'b0; rd_q <= 1'b0; done_q <= 1'b0;
      key_q <= '0;
    end else begin
      done_q <= fin;
      if (cmd_i.start) begin
        idx_q <= '0; busy_q <= 1'b1; known_q <= 1'b0; rd_q <= 1'b0; key_q <= addr_i;
      end else if (busy_q) begin
        if (hit_now) known_q <= 1'b1;
        if (fin) begin
          busy_q <= 1'b0;
          rd_q <= 1'b0;
        end else begin
          rd_q <= 1'b1;
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end
  assign srch_o.busy = busy_q;
  assign srch_o.known = known_q;
  assign srch_o.done = done_q;
endmodule

### rtl/pic_ctrl.sv
module pic_ctrl import pic_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      frame_last_i,
  input  logic      syn_i,
  input  pic_srch_t srch_i,
  input  logic      out_free_i,
  output logic      in_ready_o,
  output pic_cmd_t  cmd_o,
  output logic      finish_o
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSrch = 2'd1;
  localparam logic [1:0] StWait = 2'd2;
  logic [1:0] st_q, st_d;

  always_comb begin
    st_d = st_q;
    cmd_o.start = 1'b0;
    finish_o = 1'b0;
    in_ready_o = 1'b0;
    case (st_q)
      StIdle: begin
        in_ready_o = out_free_i;
        if (frame_last_i) begin
          if (syn_i) begin
            cmd_o.start = 1'b1;
            st_d = StSrch;
          end else st_d = StWait;
        end
      end
      StSrch: if (srch_i.done) st_d = StWait;
      StWait: if (out_free_i) begin
        finish_o = 1'b1;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= StIdle;
    else st_q <= st_d;
  end
endmodule

### rtl/packet_intrusion_classifier.sv
// Result: a non-SYN frame goes to the wait state once its last byte is accepted;
// a SYN frame first searches the stored sources (at most SOURCE_TABLE_DEPTH),
// one entry per cycle, until a match or the last entry; the result is then registered.
// Throughput: one byte per cycle within a frame; the input stalls from the
// last byte until the result is registered and while a result waits.
// Reset: rst_ni asynchronous; clears counters, table count, parser state and
// sets watched_port to 80. Table contents are not cleared.
module packet_intrusion_classifier import pic_pkg::*; #(
  parameter int SOURCE_TABLE_DEPTH = 64,
  parameter int COUNTER_WIDTH = 32,
  parameter int MAX_FRAME_BYTES = 65535
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // frame_byte
  input  logic         s_axis_tlast,   // frame_end
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // syn_seen, arp_seen, blacklist_hit, new_source, table_overflow,
  // source_address, syn_total, arp_total, blacklist_total, unique_sources, 4'b0 pad
  output logic [143:0] m_axis_tdata,
  output logic         m_axis_tlast    // frame_done
);
  localparam int CntW = $clog2(SOURCE_TABLE_DEPTH + 1);
  localparam logic [COUNTER_WIDTH-1:0] CMax = '1;

  logic [15:0] port_q;
  pic_status_t stat;
  logic arp, hit, take, finish, out_free;
  pic_cmd_t cmd;
  pic_srch_t srch;
  logic [CntW-1:0] cnt_q;
  logic [COUNTER_WIDTH-1:0] syn_c_q, arp_c_q, bl_c_q;
  logic syn_f_q, arp_f_q, hit_f_q;
  logic [31:0] src_f_q;
  logic store, fresh, over;
  logic [COUNTER_WIDTH-1:0] syn_n, arp_n, bl_n;
  logic [CntW-1:0] cnt_n;
  logic start_pipe;

  assign take = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  pic_parser #(.MaxFrameBytes(MAX_FRAME_BYTES)) u_parser (
    .clk_i, .rst_ni, .take_i(take), .byte_i(s_axis_tdata), .last_i(s_axis_tlast),
    .port_i(port_q), .stat_o(stat), .arp_o(arp), .hit_o(hit)
  );

  pic_ctrl u_ctrl (
    .clk_i, .rst_ni, .frame_last_i(take && s_axis_tlast), .syn_i(stat.syn),
    .srch_i(srch), .out_free_i(out_free), .in_ready_o(s_axis_tready),
    .cmd_o(cmd), .finish_o(finish)
  );

  pic_search #(.Depth(SOURCE_TABLE_DEPTH), .CntW(CntW)) u_search (
    .clk_i, .rst_ni, .cmd_i(cmd), .addr_i(stat.src), .store_i(store),
    .count_i(cnt_q), .srch_o(srch)
  );

  assign start_pipe = take && s_axis_tlast;
  assign fresh = syn_f_q && !srch.known && cnt_q < CntW'(SOURCE_TABLE_DEPTH);
  assign over  = syn_f_q && !srch.known && cnt_q >= CntW'(SOURCE_TABLE_DEPTH);
  assign store = finish && fresh;

  always_comb begin
    syn_n = (syn_f_q && syn_c_q != CMax) ? syn_c_q + 1'b1 : syn_c_q;
    arp_n = (arp_f_q && arp_c_q != CMax) ? arp_c_q + 1'b1 : arp_c_q;
    bl_n  = (hit_f_q && bl_c_q != CMax) ? bl_c_q + 1'b1 : bl_c_q;
    cnt_n = fresh ? cnt_q + 1'b1 : cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_q <= 16'd80;
      cnt_q <= '0; syn_c_q <= '0; arp_c_q <= '0; bl_c_q <= '0;
      syn_f_q <= 1'b0; arp_f_q <= 1'b0; hit_f_q <= 1'b0;
      src_f_q <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata <= '0;
      m_axis_tlast <= 1'b0;
    end else begin
      if (cfg_we_i) port_q <= cfg_wdata_i;
      if (start_pipe) begin
        syn_f_q <= stat.syn; arp_f_q <= arp; hit_f_q <= hit;
        src_f_q <= stat.src;
      end
      m_axis_tvalid <= finish || (m_axis_tvalid && !m_axis_tready);
      if (finish) begin
        cnt_q <= cnt_n; syn_c_q <= syn_n; arp_c_q <= arp_n; bl_c_q <= bl_n;
        m_axis_tlast <= 1'b1;
        m_axis_tdata <= {4'b0, 7'(cnt_n), 32'(bl_n), 32'(arp_n), 32'(syn_n),
                         src_f_q, over, fresh, hit_f_q, arp_f_q, syn_f_q};
      end
    end
  end
endmodule

### rtl/pic_checker.sv
module pic_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata,
  input logic         m_axis_tlast
);
`include "packet_intrusion_classifier_macros.svh"
  `PIC_ASSERT_IMP(a_last, clk_i, rst_ni, m_axis_tvalid, m_axis_tlast)
  `PIC_ASSERT_IMP(a_excl, clk_i, rst_ni, m_axis_tvalid, !(m_axis_tdata[3] && m_axis_tdata[4]))
  `PIC_ASSERT_IMP(a_newsyn, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[3], m_axis_tdata[0])
  `PIC_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `PIC_ASSERT_IMP(a_backp, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && m_axis_tvalid, m_axis_tready)
endmodule

bind packet_intrusion_classifier pic_checker u_pic_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tlast
);

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import pic_pkg::*;

  typedef struct packed {
    logic [3:0]  pad;
    logic [6:0]  uniq;
    logic [31:0] bl_total;
    logic [31:0] arp_total;
    logic [31:0] syn_total;
    logic [31:0] src;
    logic        overflow;
    logic        fresh;
    logic        hit;
    logic        arp;
    logic        syn;
  } verdict_t;

  localparam int TableDepth = 64;
  localparam int MaxFrameBytes = 65535;
  localparam logic [7:0] FlagsMask = 8'h3a;
  localparam logic [7:0] FlagSyn = 8'h02;

  typedef logic [7:0] pat_t [12];
  typedef int fail_t [12];
  localparam pat_t HostPat = '{8'h48, 8'h6f, 8'h73, 8'h74, 8'h3a,
                               0, 0, 0, 0, 0, 0, 0};
  localparam pat_t Name1Pat = '{8'h67, 8'h6f, 8'h6f, 8'h67, 8'h6c, 8'h65,
                                8'h2e, 8'h63, 8'h6f, 8'h2e, 8'h75, 8'h6b};
  localparam pat_t Name2Pat = '{8'h62, 8'h62, 8'h63, 8'h2e, 8'h63, 8'h6f,
                                8'h6d, 0, 0, 0, 0, 0};
  localparam fail_t HostFail = '{default: 0};
  localparam fail_t Name1Fail = '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0};
  localparam fail_t Name2Fail = '{0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  class frame_scoreboard;
    logic [15:0] watched_port;
    int unsigned offset, ether, ihl, proto, src_acc, dport, doff, flags;
    int unsigned host_pos, n1_pos, n2_pos;
    bit host_found, name_hit;
    logic [31:0] sources [TableDepth];
    int unsigned source_count;
    logic [31:0] syn_cnt, arp_cnt, bl_cnt;
    verdict_t expected [$];
    int errors;

    function new();
      watched_port = 16'd80;
      source_count = 0;
      syn_cnt = 0;
      arp_cnt = 0;
      bl_cnt = 0;
      errors = 0;
      clear();
    endfunction

    function void clear();
      offset = 0; ether = 0; ihl = 0; proto = 0; src_acc = 0; dport = 0;
      doff = 0; flags = 0; host_pos = 0; n1_pos = 0; n2_pos = 0;
      host_found = 0; name_hit = 0;
    endfunction

    function int unsigned kmp(pat_t pat, fail_t fl, int unsigned len,
                              int unsigned pos, logic [7:0] c);
      if (pos >= len) pos = 0;
      while (pos > 0 && pat[pos] != c) pos = fl[pos-1];
      if (pat[pos] == c) pos++;
      return pos;
    endfunction

    function logic [31:0] sat(logic [31:0] v);
      return (v == 32'hffff_ffff) ? v : v + 1;
    endfunction

    function void parse(int unsigned o, logic [7:0] b);
      int unsigned t;
      bit tcp_ok;
      t = 14 + 4 * ihl;
      tcp_ok = ether == 16'h0800 && ihl >= 5 && proto == 6;
      if (o == 12) ether = b << 8;
      else if (o == 13) ether |= b;
      else if (o == 14) ihl = b & 15;
      else if (o == 23) proto = b;
      else if (o >= 26 && o <= 29) src_acc = (src_acc << 8) | b;
      if (!tcp_ok || o < t) return;
      if (o == t + 2) dport = b << 8;
      else if (o == t + 3) dport |= b;
      else if (o == t + 12) doff = b >> 4;
      else if (o == t + 13) flags = b;
      if (doff >= 5 && o >= t + 4 * doff && dport == watched_port && !name_hit) begin
        if (!host_found) begin
          host_pos = kmp(HostPat, HostFail, 5, host_pos, b);
          if (host_pos == 5) host_found = 1;
        end else begin
          n1_pos = kmp(Name1Pat, Name1Fail, 12, n1_pos, b);
          n2_pos = kmp(Name2Pat, Name2Fail, 7, n2_pos, b);
          if (n1_pos == 12 || n2_pos == 7) name_hit = 1;
        end
      end
    endfunction

    function void note_item(logic [7:0] b, logic last);
      verdict_t v;
      bit ipv4, known;
      int unsigned p;
      if (offset < MaxFrameBytes) begin
        parse(offset, b);
        offset++;
      end
      if (!last) return;
      v = '0;
      ipv4 = ether == 16'h0800 && offset >= 14;
      v.arp = ether == 16'h0806 && offset >= 14;
      v.src = (ipv4 && offset >= 30) ? src_acc : 0;
      p = 14 + 4 * ihl + 4 * doff;
      if (ipv4 && ihl >= 5 && proto == 6 && doff >= 5 && offset >= p)
        v.syn = (flags & FlagsMask) == FlagSyn;
      v.hit = name_hit;
      if (v.syn) begin
        known = 0;
        for (int i = 0; i < source_count; i++)
          if (sources[i] == v.src) known = 1;
        if (!known) begin
          if (source_count < TableDepth) begin
            sources[source_count] = v.src;
            source_count++;
            v.fresh = 1;
          end else begin
            v.overflow = 1;
          end
        end
        syn_cnt = sat(syn_cnt);
      end
      if (v.arp) arp_cnt = sat(arp_cnt);
      if (v.hit) bl_cnt = sat(bl_cnt);
      v.syn_total = syn_cnt;
      v.arp_total = arp_cnt;
      v.bl_total = bl_cnt;
      v.uniq = source_count[6:0];
      expected.push_back(v);
      clear();
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(logic [143:0] data, logic last);
      verdict_t e, a;
      if (expected.size() == 0) begin
        $error("result with no frame pending");
        errors++;
        return;
      end
      e = expected.pop_front();
      a = data;
      cmp("syn_seen", e.syn, a.syn);
      cmp("arp_seen", e.arp, a.arp);
      cmp("blacklist_hit", e.hit, a.hit);
      cmp("new_source", e.fresh, a.fresh);
      cmp("table_overflow", e.overflow, a.overflow);
      cmp("source_address", e.src, a.src);
      cmp("syn_total", e.syn_total, a.syn_total);
      cmp("arp_total", e.arp_total, a.arp_total);
      cmp("blacklist_total", e.bl_total, a.bl_total);
      cmp("unique_sources", e.uniq, a.uniq);
      cmp("frame_done", 1, last);
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [15:0] cfg_wdata_i = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [143:0] m_axis_tdata;
  logic m_axis_tlast;

  frame_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  logic [7:0] frm [$];

  packet_intrusion_classifier uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_frame();
    for (int i = 0; i < frm.size(); i++) begin
      while ($urandom_range(99) < idle_pct) begin
        s_axis_tvalid <= 0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1;
      s_axis_tdata <= frm[i];
      s_axis_tlast <= (i == frm.size() - 1);
      do @(posedge clk_i); while (!s_axis_tready);
      sb.note_item(frm[i], i == frm.size() - 1);
      items_sent++;
    end
    s_axis_tvalid <= 0;
    @(posedge clk_i);
  endtask

  task automatic push_rand(int n);
    repeat (n) frm.push_back(8'($urandom));
  endtask

  task automatic push_pat(pat_t pat, int len);
    for (int i = 0; i < len; i++) frm.push_back(pat[i]);
  endtask

  // payload modes: 0 empty, 1 random, 2/3 host then name, 4 name before host,
  // 5 host then partial name, 6 overlapping prefixes
  task automatic build_tcp(logic [15:0] ether, logic [3:0] ihl, logic [7:0] proto,
                           logic [31:0] src, logic [15:0] dport, logic [3:0] doff,
                           logic [7:0] flags, int mode, int cut);
    int t;
    frm.delete();
    push_rand(12);
    frm.push_back(ether[15:8]);
    frm.push_back(ether[7:0]);
    frm.push_back({4'($urandom), ihl});
    push_rand(8);
    frm.push_back(proto);
    push_rand(2);
    for (int i = 3; i >= 0; i--) frm.push_back(src[8*i +: 8]);
    t = 14 + 4 * ((ihl < 5) ? 5 : ihl);
    push_rand(t - frm.size());
    push_rand(2);
    frm.push_back(dport[15:8]);
    frm.push_back(dport[7:0]);
    push_rand(8);
    frm.push_back({doff, 4'($urandom)});
    frm.push_back(flags);
    push_rand(t + 4 * ((doff < 5) ? 5 : doff) - frm.size());
    case (mode)
      1: push_rand($urandom_range(1, 20));
      2, 3, 5: begin
        push_rand($urandom_range(0, 4));
        push_pat(HostPat, 5);
        push_rand($urandom_range(0, 4));
        if (mode == 2) push_pat(Name1Pat, 12);
        else if (mode == 3) push_pat(Name2Pat, 7);
        else push_pat(Name1Pat, $urandom_range(1, 11));
        push_rand($urandom_range(0, 4));
      end
      4: begin
        push_pat(Name2Pat, 7);
        push_pat(HostPat, 5);
        push_pat(Name1Pat, 11);
      end
      6: begin
        push_pat(HostPat, 5);
        push_pat(Name1Pat, 3);
        push_pat(Name1Pat, 12);
        frm.push_back(Name2Pat[0]);
        push_pat(Name2Pat, 7);
      end
      default: ;
    endcase
    if (cut > 0 && cut < frm.size()) frm = frm[0:cut-1];
  endtask

  task automatic build_plain(logic [15:0] ether, int len);
    frm.delete();
    push_rand(len);
    if (len > 13) begin
      frm[12] = ether[15:8];
      frm[13] = ether[7:0];
    end
  endtask

  task automatic write_port(logic [15:0] v);
    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.watched_port = v;
  endtask

  task automatic random_frame();
    int r;
    logic [31:0] src;
    logic [15:0] port;
    r = $urandom_range(99);
    src = ($urandom_range(3) == 0) ? $urandom : {24'h0a0000, 8'($urandom_range(90))};
    port = ($urandom_range(4) != 0) ? sb.watched_port : 16'($urandom);
    if (r < 65)
      build_tcp(EtherIpv4, 4'($urandom_range(5, 7)), ProtoTcp, src, port,
                4'($urandom_range(5, 7)),
                ($urandom_range(1) != 0) ? FlagSyn : 8'($urandom),
                $urandom_range(0, 6), 0);
    else if (r < 75)
      build_plain(EtherArp, $urandom_range(14, 60));
    else if (r < 85)
      build_plain(16'($urandom), $urandom_range(1, 80));
    else if (r < 95)
      build_tcp(EtherIpv4, 5, ProtoTcp, src, port, 5, FlagSyn,
                $urandom_range(0, 6), $urandom_range(1, 70));
    else
      build_tcp(EtherIpv4, 4'($urandom_range(15)), 8'($urandom), src, port,
                4'($urandom_range(15)), 8'($urandom), $urandom_range(0, 6), 0);
    send_frame();
  endtask

  initial begin
    int base;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    write_port(16'd80);

    build_tcp(EtherIpv4, 5, ProtoTcp, 32'h0a000001, 80, 5, FlagSyn, 0, 0); send_frame();
    build_tcp(EtherIpv4, 5, ProtoTcp, 32'h0a000001, 80, 5, FlagSyn, 0, 0); send_frame();
    build_tcp(EtherIpv4, 5, ProtoTcp, 32'h0, 80, 5, 8'h12, 0, 0); send_frame();
    build_tcp(EtherIpv4, 5, ProtoTcp, 32'hffffffff, 80, 5, 8'hff, 0, 0); send_frame();
    build_tcp(EtherIpv4, 5, ProtoTcp, 32'h0, 80, 5, FlagSyn, 0, 0); send_frame();
    build_tcp(EtherIpv4, 15, ProtoTcp, 32'hffffffff, 80, 15, 8'hc6, 2, 0); send_frame();
    build_tcp(EtherIpv4, 5, ProtoTcp, 32'h01020304, 80, 5, 8'h18, 2, 0); send_frame();
    build_tcp(EtherIpv4, 5, ProtoTcp, 32'h01020304, 80, 5, 8'h18, 3, 0); send_frame();
    build_tcp(EtherIpv4, 5, ProtoTcp, 32'h01020304, 80, 5, 8'h18, 4, 0); send_frame();
    build_tcp(EtherIpv4, 5, ProtoTcp, 32'h01020304, 80, 5, 8'h18, 5, 0); send_frame();
    build_tcp(EtherIpv4, 5, ProtoTcp, 32'h01020304, 80, 5, 8'h18, 6, 0); send_frame();
    build_tcp(EtherIpv4, 5, ProtoTcp, 32'h01020304, 81, 5, 8'h18, 2, 0); send_frame();
    build_tcp(EtherIpv4, 4, ProtoTcp, 32'h01020305, 80, 5, FlagSyn, 2, 0); send_frame();
    build_tcp(EtherIpv4, 5, ProtoTcp, 32'h01020306, 80, 4, FlagSyn, 2, 0); send_frame();
    build_tcp(EtherIpv4, 5, 8'd17, 32'h01020307, 80, 5, FlagSyn, 2, 0); send_frame();
    build_tcp(EtherIpv4, 5, ProtoTcp, 32'h01020308, 80, 5, FlagSyn, 2, 60); send_frame();
    build_tcp(EtherIpv4, 5, ProtoTcp, 32'h01020309, 80, 5, FlagSyn, 0, 53); send_frame();
    build_tcp(EtherIpv4, 5, ProtoTcp, 32'h0102030a, 80, 5, FlagSyn, 0, 29); send_frame();
    build_plain(EtherArp, 14); send_frame();
    build_plain(EtherArp, 13); send_frame();
    build_plain(16'hffff, 1); send_frame();

    base = items_sent;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_port(16'd0); idle_pct = 0; stall_pct = 0; end
        1: begin write_port(16'hffff); idle_pct = 58; stall_pct = 0; end
        2: begin write_port(16'($urandom)); idle_pct = 0; stall_pct = 58; end
        default: begin write_port(16'd80); idle_pct = 28; stall_pct = 28; end
      endcase
      while (items_sent < base + 200 * (ph + 1)) random_frame();
    end

    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
